// ===== rtl/met_pkg.sv =====
// Shared types, constants and helpers for the escape-time block.
// No dependencies; every other file imports this package.
package met_pkg;

    // Fixed point format: signed Q8.FRAC_BITS
    localparam int FRAC_BITS = 40;
    localparam int MAX_DIM   = 2048;

    localparam int Q_W      = FRAC_BITS + 8;
    localparam int HALF_W   = (Q_W + 1) / 2;
    localparam int ACC_W    = 4 * HALF_W;

    localparam int IDX_W    = 11;
    localparam int EDGE_W   = 6;
    localparam int DIM_W    = 12;
    localparam int ITER_W   = 17;
    localparam int DIMC_W   = $clog2(MAX_DIM + 1);
    localparam int NUM_W    = IDX_W + EDGE_W;
    localparam int QUO_W    = NUM_W + FRAC_BITS;
    localparam int IP_W     = NUM_W + 2;
    localparam int CNT_W    = $clog2(QUO_W);

    localparam int MUL_STEPS = 4;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = ITER_W;

    localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};
    localparam logic [Q_W:0] LSQ_LIMIT = (Q_W+1)'(4) << FRAC_BITS;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_X_LEFT   = 3'd0,
        CFG_X_RIGHT  = 3'd1,
        CFG_Y_LEFT   = 3'd2,
        CFG_Y_RIGHT  = 3'd3,
        CFG_WIDTH    = 3'd4,
        CFG_HEIGHT   = 3'd5,
        CFG_MAX_ITER = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic signed [EDGE_W-1:0] x_left;
        logic signed [EDGE_W-1:0] x_right;
        logic signed [EDGE_W-1:0] y_left;
        logic signed [EDGE_W-1:0] y_right;
        logic [DIM_W-1:0]         image_width;
        logic [DIM_W-1:0]         image_height;
        logic [ITER_W-1:0]        max_iterations;
    } t_cfg;

    typedef struct packed {
        logic [IDX_W-1:0] column;
        logic [IDX_W-1:0] row;
    } t_req;

    typedef struct packed {
        logic [ITER_W-1:0] iteration_count;
        logic [IDX_W-1:0]  column_out;
        logic [IDX_W-1:0]  row_out;
    } t_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_FIX,
        S_MUL,
        S_SAT,
        S_CHECK,
        S_STEP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic       load;
        logic       div_step;
        logic       fix;
        logic       mul_issue;
        logic [1:0] mul_sel;
        logic       mul_acc;
        logic       mul_first;
        logic       sat;
        logic       check;
        logic       step;
        logic       out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic go_on;
        logic out_free;
    } t_dp_sts;

    // Saturating Q8 add
    function automatic logic signed [Q_W-1:0] sat_add(
        input logic signed [Q_W-1:0] a,
        input logic signed [Q_W-1:0] b
    );
        logic signed [Q_W:0] s;
        s = {a[Q_W-1], a} + {b[Q_W-1], b};
        if (s[Q_W] != s[Q_W-1]) begin
            sat_add = s[Q_W] ? Q_MIN : Q_MAX;
        end else begin
            sat_add = s[Q_W-1:0];
        end
    endfunction

endpackage

// ===== rtl/mandelbrot_escape_time.sv =====
// Channel    Direction  Handshake             Payload
// request    in         i_req_valid/o_req_stall  t_req  (column, row)
// response   out        o_rsp_valid/i_rsp_stall  t_rsp  (iteration_count, column_out, row_out)
// config     in         i_cfg_we (no wait)       i_cfg_addr, i_cfg_data
//
// One request at a time: the block takes no new request until the last is in the output register.
// Each iteration is one multiply pass of four partial products on three shared lanes,
// plus saturate, escape check and z update; the coordinate divider runs once per request.
// A finished response sits in the output register; the next request is taken meanwhile.
// Synchronous active-low reset restores the register defaults and empties the output.
// Top level: configuration registers, controller and datapath. Uses met_pkg.
module mandelbrot_escape_time import met_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    output logic                  o_req_stall,
    input  t_req                  i_req,
    output logic                  o_rsp_valid,
    input  logic                  i_rsp_stall,
    output t_rsp                  o_rsp,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg    r_cfg;
    t_dp_cmd cmd;
    t_dp_sts sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x_left         <= -EDGE_W'(2);
            r_cfg.x_right        <= EDGE_W'(2);
            r_cfg.y_left         <= -EDGE_W'(2);
            r_cfg.y_right        <= EDGE_W'(2);
            r_cfg.image_width    <= DIM_W'(800);
            r_cfg.image_height   <= DIM_W'(800);
            r_cfg.max_iterations <= ITER_W'(100000);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_X_LEFT:   r_cfg.x_left         <= i_cfg_data[EDGE_W-1:0];
                CFG_X_RIGHT:  r_cfg.x_right        <= i_cfg_data[EDGE_W-1:0];
                CFG_Y_LEFT:   r_cfg.y_left         <= i_cfg_data[EDGE_W-1:0];
                CFG_Y_RIGHT:  r_cfg.y_right        <= i_cfg_data[EDGE_W-1:0];
                CFG_WIDTH:    r_cfg.image_width    <= i_cfg_data[DIM_W-1:0];
                CFG_HEIGHT:   r_cfg.image_height   <= i_cfg_data[DIM_W-1:0];
                CFG_MAX_ITER: r_cfg.max_iterations <= i_cfg_data[ITER_W-1:0];
                default: ;
            endcase
        end
    end

    met_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    met_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_req       (i_req),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_rsp       (o_rsp)
    );

endmodule

// ===== rtl/met_coord.sv =====
// Pixel index to Q8 coordinate: restoring divider, one quotient bit per cycle,
// then sign fix-up and saturation. Depends on met_pkg.
module met_coord import met_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_init,
    input  logic                     i_step,
    input  logic                     i_fix,
    input  logic [IDX_W-1:0]         i_idx,
    input  logic signed [EDGE_W-1:0] i_lo,
    input  logic signed [EDGE_W-1:0] i_hi,
    input  logic [DIM_W-1:0]         i_dim,
    output logic signed [Q_W-1:0]    o_c
);

    localparam int IP_HI = 127;
    localparam int IP_LO = -128;

    logic signed [EDGE_W:0]   range_s;
    logic [EDGE_W-1:0]        range_mag;
    logic [DIMC_W-1:0]        w;
    logic [NUM_W-1:0]         prod;
    logic [DIMC_W:0]          rem_sh;
    logic                     ge;
    logic [DIMC_W:0]          rem_nx;
    logic [NUM_W-1:0]         q;
    logic [FRAC_BITS-1:0]     f;
    logic                     f_nz;
    logic signed [IP_W-1:0]   lo_ext;
    logic signed [IP_W-1:0]   q_ext;
    logic signed [IP_W-1:0]   ip;
    logic [FRAC_BITS-1:0]     f_out;
    logic signed [Q_W-1:0]    c_val;

    logic [QUO_W-1:0]         r_num;
    logic [DIMC_W-1:0]        r_rem;
    logic [DIMC_W-1:0]        r_w;
    logic                     r_neg;
    logic signed [Q_W-1:0]    r_c;

    always_comb begin
        range_s   = {i_hi[EDGE_W-1], i_hi} - {i_lo[EDGE_W-1], i_lo};
        range_mag = range_s[EDGE_W] ? EDGE_W'(-range_s) : range_s[EDGE_W-1:0];
        // zero width acts as one, oversize clamps
        if (i_dim == '0) begin
            w = DIMC_W'(1);
        end else if (32'(i_dim) > 32'(MAX_DIM)) begin
            w = DIMC_W'(MAX_DIM);
        end else begin
            w = DIMC_W'(i_dim);
        end
        prod = NUM_W'(i_idx) * NUM_W'(range_mag);
    end

    always_comb begin
        rem_sh = {r_rem, r_num[QUO_W-1]};
        ge     = rem_sh >= {1'b0, r_w};
        rem_nx = ge ? rem_sh - {1'b0, r_w} : rem_sh;
    end

    // negative span: floor toward the low edge, fraction complemented
    always_comb begin
        q      = r_num[QUO_W-1:FRAC_BITS];
        f      = r_num[FRAC_BITS-1:0];
        f_nz   = |f;
        lo_ext = IP_W'(i_lo);
        q_ext  = signed'({2'b00, q});
        if (r_neg) begin
            ip = lo_ext - q_ext - IP_W'(signed'({1'b0, f_nz}));
        end else begin
            ip = lo_ext + q_ext;
        end
        f_out = (r_neg && f_nz) ? -f : f;
        if (ip > IP_W'(IP_HI)) begin
            c_val = Q_MAX;
        end else if (ip < IP_W'(IP_LO)) begin
            c_val = Q_MIN;
        end else begin
            c_val = {ip[7:0], f_out};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_init) begin
            r_num <= {prod, {FRAC_BITS{1'b0}}};
            r_rem <= '0;
            r_w   <= w;
            r_neg <= range_s[EDGE_W];
        end else if (i_step) begin
            r_num <= {r_num[QUO_W-2:0], ge};
            r_rem <= rem_nx[DIMC_W-1:0];
        end
        if (i_fix) begin
            r_c <= c_val;
        end
    end

    assign o_c = r_c;

endmodule

// ===== rtl/met_mul.sv =====
// Q8 multiply lane: one half-width multiplier, four partial products
// accumulated over cycles, then truncate toward zero and saturate. Uses met_pkg.
module met_mul import met_pkg::*; (
    input  logic                  i_clk,
    input  logic signed [Q_W-1:0] i_a,
    input  logic signed [Q_W-1:0] i_b,
    input  logic                  i_issue,
    input  logic [1:0]            i_sel,
    input  logic                  i_acc,
    input  logic                  i_first,
    input  logic                  i_sat,
    output logic signed [Q_W-1:0] o_p
);

    logic [Q_W-1:0]          mag_a;
    logic [Q_W-1:0]          mag_b;
    logic [2*HALF_W-1:0]     a_pad;
    logic [2*HALF_W-1:0]     b_pad;
    logic [HALF_W-1:0]       a_half;
    logic [HALF_W-1:0]       b_half;
    logic [ACC_W-1:0]        term;
    logic                    neg;
    logic                    ovf;
    logic signed [Q_W-1:0]   mag;
    logic signed [Q_W-1:0]   p_val;

    logic [2*HALF_W-1:0]     r_pp;
    logic [1:0]              r_sh;
    logic [ACC_W-1:0]        r_acc;
    logic signed [Q_W-1:0]   r_p;

    always_comb begin
        mag_a  = i_a[Q_W-1] ? -i_a : i_a;
        mag_b  = i_b[Q_W-1] ? -i_b : i_b;
        a_pad  = (2*HALF_W)'(mag_a);
        b_pad  = (2*HALF_W)'(mag_b);
        a_half = i_sel[0] ? a_pad[2*HALF_W-1:HALF_W] : a_pad[HALF_W-1:0];
        b_half = i_sel[1] ? b_pad[2*HALF_W-1:HALF_W] : b_pad[HALF_W-1:0];
    end

    always_comb begin
        unique case (r_sh)
            2'd0:    term = ACC_W'(r_pp);
            2'd1:    term = ACC_W'(r_pp) << HALF_W;
            default: term = ACC_W'(r_pp) << (2 * HALF_W);
        endcase
    end

    always_comb begin
        neg = i_a[Q_W-1] ^ i_b[Q_W-1];
        ovf = |r_acc[ACC_W-1:FRAC_BITS+Q_W-1];
        mag = signed'({1'b0, r_acc[FRAC_BITS+Q_W-2:FRAC_BITS]});
        if (ovf) begin
            p_val = neg ? Q_MIN : Q_MAX;
        end else begin
            p_val = neg ? -mag : mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_issue) begin
            r_pp <= a_half * b_half;
            r_sh <= {1'b0, i_sel[0]} + {1'b0, i_sel[1]};
        end
        if (i_acc) begin
            r_acc <= i_first ? term : r_acc + term;
        end
        if (i_sat) begin
            r_p <= p_val;
        end
    end

    assign o_p = r_p;

endmodule

// ===== rtl/met_dp.sv =====
// Datapath: coordinate lanes, three multiply lanes, z update, iteration count
// and the result register. Uses met_pkg, met_coord and met_mul.
module met_dp import met_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  t_req    i_req,
    input  t_dp_cmd i_cmd,
    output t_dp_sts o_sts,
    output logic    o_rsp_valid,
    input  logic    i_rsp_stall,
    output t_rsp    o_rsp
);

    logic signed [Q_W-1:0] cr;
    logic signed [Q_W-1:0] ci;
    logic signed [Q_W-1:0] rr;
    logic signed [Q_W-1:0] ii;
    logic signed [Q_W-1:0] ri;
    logic [Q_W:0]          lsq;

    logic signed [Q_W-1:0] r_zr;
    logic signed [Q_W-1:0] r_zi;
    logic signed [Q_W-1:0] r_tr;
    logic signed [Q_W-1:0] r_ti;
    logic [ITER_W-1:0]     r_count;
    logic [IDX_W-1:0]      r_col;
    logic [IDX_W-1:0]      r_row;
    t_rsp                  r_rsp;
    logic                  r_rsp_valid;

    met_coord u_coord_re (
        .i_clk  (i_clk),
        .i_init (i_cmd.load),
        .i_step (i_cmd.div_step),
        .i_fix  (i_cmd.fix),
        .i_idx  (i_req.column),
        .i_lo   (i_cfg.x_left),
        .i_hi   (i_cfg.x_right),
        .i_dim  (i_cfg.image_width),
        .o_c    (cr)
    );

    met_coord u_coord_im (
        .i_clk  (i_clk),
        .i_init (i_cmd.load),
        .i_step (i_cmd.div_step),
        .i_fix  (i_cmd.fix),
        .i_idx  (i_req.row),
        .i_lo   (i_cfg.y_left),
        .i_hi   (i_cfg.y_right),
        .i_dim  (i_cfg.image_height),
        .o_c    (ci)
    );

    met_mul u_mul_rr (
        .i_clk   (i_clk),
        .i_a     (r_zr),
        .i_b     (r_zr),
        .i_issue (i_cmd.mul_issue),
        .i_sel   (i_cmd.mul_sel),
        .i_acc   (i_cmd.mul_acc),
        .i_first (i_cmd.mul_first),
        .i_sat   (i_cmd.sat),
        .o_p     (rr)
    );

    met_mul u_mul_ii (
        .i_clk   (i_clk),
        .i_a     (r_zi),
        .i_b     (r_zi),
        .i_issue (i_cmd.mul_issue),
        .i_sel   (i_cmd.mul_sel),
        .i_acc   (i_cmd.mul_acc),
        .i_first (i_cmd.mul_first),
        .i_sat   (i_cmd.sat),
        .o_p     (ii)
    );

    met_mul u_mul_ri (
        .i_clk   (i_clk),
        .i_a     (r_zr),
        .i_b     (r_zi),
        .i_issue (i_cmd.mul_issue),
        .i_sel   (i_cmd.mul_sel),
        .i_acc   (i_cmd.mul_acc),
        .i_first (i_cmd.mul_first),
        .i_sat   (i_cmd.sat),
        .o_p     (ri)
    );

    // squares are never negative, so the saturated sum only matters above the limit
    always_comb begin
        lsq            = {1'b0, rr} + {1'b0, ii};
        o_sts.go_on    = (r_count < i_cfg.max_iterations) && (lsq < LSQ_LIMIT);
        o_sts.out_free = !r_rsp_valid || !i_rsp_stall;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_zr    <= '0;
            r_zi    <= '0;
            r_count <= '0;
            r_col   <= i_req.column;
            r_row   <= i_req.row;
        end
        if (i_cmd.check) begin
            r_tr <= sat_add(rr, -ii);
            r_ti <= sat_add(ri, ri);
        end
        if (i_cmd.step) begin
            r_zr    <= sat_add(r_tr, cr);
            r_zi    <= sat_add(r_ti, ci);
            r_count <= r_count + 1'b1;
        end
        if (i_cmd.out_load) begin
            r_rsp.iteration_count <= r_count;
            r_rsp.column_out      <= r_col;
            r_rsp.row_out         <= r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_rsp_valid <= 1'b1;
        end else if (!i_rsp_stall) begin
            r_rsp_valid <= 1'b0;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

// ===== rtl/met_ctrl.sv =====
// Controller: sequences division, multiply passes and the z update per request.
// Uses met_pkg; drives met_dp through t_dp_cmd.
module met_ctrl import met_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_req_valid,
    output logic    o_req_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(QUO_W - 1);
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MUL_STEPS);

    t_state            r_state;
    t_state            n_state;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state = S_DIV;
                    n_cnt   = '0;
                end
            end
            S_DIV: begin
                if (r_cnt == DIV_LAST) begin
                    n_state = S_FIX;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_FIX: begin
                n_state = S_MUL;
                n_cnt   = '0;
            end
            S_MUL: begin
                if (r_cnt == MUL_LAST) begin
                    n_state = S_SAT;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_SAT:   n_state = S_CHECK;
            S_CHECK: n_state = i_sts.go_on ? S_STEP : S_DONE;
            S_STEP: begin
                n_state = S_MUL;
                n_cnt   = '0;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_req_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_req_stall = 1'b0;
                o_cmd.load  = i_req_valid;
            end
            S_DIV: o_cmd.div_step = 1'b1;
            S_FIX: o_cmd.fix = 1'b1;
            S_MUL: begin
                // issue on counts 0..3, accumulate each product on the count after its issue
                o_cmd.mul_issue = r_cnt != MUL_LAST;
                o_cmd.mul_sel   = r_cnt[1:0];
                o_cmd.mul_acc   = r_cnt != '0;
                o_cmd.mul_first = r_cnt == CNT_W'(1);
            end
            S_SAT:   o_cmd.sat = 1'b1;
            S_CHECK: o_cmd.check = 1'b1;
            S_STEP:  o_cmd.step = 1'b1;
            S_DONE:  o_cmd.out_load = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== rtl/met_chk.sv =====
// Port-level checks for the escape-time block, bound to the top level.
// Uses met_pkg for the payload types.
module met_chk import met_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_req_valid,
    input logic                  o_req_stall,
    input logic                  o_rsp_valid,
    input logic                  i_rsp_stall,
    input t_rsp                  o_rsp
);

    // a taken request keeps the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && !o_req_stall) |=> o_req_stall)
        else $error("request accepted but block not busy");

    // a response is only produced out of the busy phase
    a_rsp_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp_valid) |-> $past(o_req_stall))
        else $error("response appeared without a request in flight");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp_valid)
        else $error("response valid after reset");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && i_rsp_stall) |=> (o_rsp_valid && $stable(o_rsp)))
        else $error("stalled response dropped or changed");

endmodule

bind mandelbrot_escape_time met_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req_valid),
    .o_req_stall (o_req_stall),
    .o_rsp_valid (o_rsp_valid),
    .i_rsp_stall (i_rsp_stall),
    .o_rsp       (o_rsp)
);
